// ----- design/lfu_pkg.sv -----
`default_nettype none

package lfu_pkg;

    // Sizing of the slot row
    localparam int CAPACITY  = 64;
    localparam int LEVELS    = 10;
    localparam int KEY_WIDTH = 32;

    // Fixed port widths
    localparam int IN_KEY_W = 32;
    localparam int CFG_W    = 7;
    localparam int TALLY_W  = 32;

    localparam int LEVEL_W = $clog2(LEVELS);
    localparam int RANK_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(64);

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [LEVEL_W-1:0]   t_level;
    typedef logic [RANK_W-1:0]    t_rank;
    typedef logic [CNT_W-1:0]     t_count;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PROMOTE,
        OP_INSERT,
        OP_EVICT
    } t_op;

    // Broadcast to every slot cell when a key is taken in
    typedef struct packed {
        logic   capture;
        t_key   key;
        t_level vic_level;
        t_rank  vic_rank;
    } t_probe;

    // Broadcast to every slot cell when the decision is committed
    typedef struct packed {
        logic   commit;
        t_op    op;
        t_level lv;
        t_level lv_next;
        t_rank  rk;
        t_rank  new_rank;
        t_key   key;
    } t_cmd;

    // Per-cell status; level and rank are zero unless the cell matched
    typedef struct packed {
        logic   valid;
        logic   match;
        logic   free;
        logic   victim;
        t_level level;
        t_rank  rank;
    } t_report;

endpackage

`default_nettype wire

// ----- design/lfu_cell.sv -----
`default_nettype none

module lfu_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lfu_pkg::t_probe  i_probe,
    input  lfu_pkg::t_cmd    i_cmd,
    input  logic             i_free_in,
    output logic             o_free_out,
    output lfu_pkg::t_report o_report
);
    import lfu_pkg::*;

    logic   r_valid;
    logic   r_match;
    logic   r_free;
    logic   r_victim;
    t_key   r_key;
    t_level r_level;
    t_rank  r_rank;

    t_key   n_key;
    t_level n_level;
    t_rank  n_rank;

    // free token: set once any cell up the row is empty
    assign o_free_out = i_free_in | ~r_valid;

    always_comb begin
        o_report.valid  = r_valid;
        o_report.match  = r_match;
        o_report.free   = r_free;
        o_report.victim = r_victim;
        o_report.level  = r_match ? r_level : '0;
        o_report.rank   = r_match ? r_rank : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_match  <= 1'b0;
            r_free   <= 1'b0;
            r_victim <= 1'b0;
        end else begin
            if (i_probe.capture) begin
                r_match  <= r_valid && (r_key == i_probe.key);
                r_free   <= ~r_valid & ~i_free_in;
                r_victim <= r_valid && (r_level == i_probe.vic_level)
                            && (r_rank == i_probe.vic_rank);
            end
            if (i_cmd.commit && (i_cmd.op == OP_INSERT) && r_free) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_comb begin
        n_key   = r_key;
        n_level = r_level;
        n_rank  = r_rank;
        if (i_cmd.commit) begin
            case (i_cmd.op)
                OP_PROMOTE: begin
                    if (r_match) begin
                        n_level = i_cmd.lv_next;
                        n_rank  = '0;
                    end else if (r_valid && (r_level == i_cmd.lv) && (r_rank > i_cmd.rk)) begin
                        n_rank = r_rank - t_rank'(1);
                    end else if (r_valid && (r_level == i_cmd.lv_next)) begin
                        n_rank = r_rank + t_rank'(1);
                    end
                end
                OP_INSERT: begin
                    if (r_free) begin
                        n_key   = i_cmd.key;
                        n_level = '0;
                        n_rank  = '0;
                    end else if (r_valid && (r_level == '0)) begin
                        n_rank = r_rank + t_rank'(1);
                    end
                end
                OP_EVICT: begin
                    if (r_victim) begin
                        n_key   = i_cmd.key;
                        n_level = '0;
                        n_rank  = i_cmd.new_rank;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_level <= n_level;
        r_rank  <= n_rank;
    end

endmodule

`default_nettype wire

// ----- design/lfu_level_cache_policy_unit.sv -----
// Flow: on acceptance the slot cells capture their compare flags and the state
//   moves to ST_DECIDE; the commit registers the result, held off while the output register is stalled.
// Input side: a new transaction is taken only after the current one commits;
//   the slot cell row first captures the compare flags, then commits the update.
// Reset: synchronous, active low; clears slot valids, level counts, occupancy,
//   hit tally and output valid, and loads capacity with 64. No clearing pass.
`default_nettype none

module lfu_level_cache_policy_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [lfu_pkg::IN_KEY_W-1:0] i_access_key,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_hit,
    output logic [lfu_pkg::TALLY_W-1:0]        o_hit_total,
    input  logic                               i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]          i_cfg_data
);
    import lfu_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_DECIDE
    } t_state;

    t_state               r_state;
    logic                 r_out_valid;
    logic                 r_hit;
    logic [TALLY_W-1:0]   r_total;

    logic [CFG_W-1:0]     r_cap;
    t_count               r_occ;
    logic [TALLY_W-1:0]   r_tally;
    t_count               r_lvl_cnt [LEVELS];
    t_key                 r_key;

    t_count               n_occ;
    logic [TALLY_W-1:0]   n_tally;
    t_count               n_lvl_cnt [LEVELS];

    logic                 w_accept;
    logic                 w_commit;
    t_probe               w_probe;
    t_cmd                 w_cmd;
    t_op                  w_op;
    t_report              w_rpt [CAPACITY];
    logic [CAPACITY:0]    w_free_chain;

    logic                 w_any_hit;
    t_level               w_hit_lv;
    t_rank                w_hit_rk;
    logic [CAPACITY-1:0]  w_valid_vec;
    logic [CAPACITY-1:0]  w_match_vec;
    logic [CAPACITY-1:0]  w_free_vec;
    logic [CAPACITY-1:0]  w_victim_vec;

    t_level               w_vic_lv;
    t_count               w_vic_cnt;
    t_rank                w_vic_rk;
    logic [CMP_W-1:0]     w_cap_eff;

    // ---------------------------------------------------------------
    // Handshake: one transaction in flight; the output register decouples
    // the result from the next transaction on the input side.
    // ---------------------------------------------------------------
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_commit    = (r_state == ST_DECIDE) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_hit_total = r_total;

    // ---------------------------------------------------------------
    // Victim choice: back entry of the lowest level that holds anything.
    // Ranks within a level are always packed 0..count-1, so the back entry
    // sits at rank count-1.
    // ---------------------------------------------------------------
    always_comb begin
        w_vic_lv  = '0;
        w_vic_cnt = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_lvl_cnt[l] != '0) begin
                w_vic_lv  = t_level'(l);
                w_vic_cnt = r_lvl_cnt[l];
            end
        end
        w_vic_rk = t_rank'(w_vic_cnt - t_count'(1));
    end

    // Capacity register, zero read as one and clipped to the slot count
    always_comb begin
        w_cap_eff = CMP_W'(r_cap);
        if (w_cap_eff == '0) begin
            w_cap_eff = CMP_W'(1);
        end else if (w_cap_eff > CMP_W'(CAPACITY)) begin
            w_cap_eff = CMP_W'(CAPACITY);
        end
    end

    always_comb begin
        w_probe.capture   = w_accept;
        w_probe.key       = t_key'(i_access_key);
        w_probe.vic_level = w_vic_lv;
        w_probe.vic_rank  = w_vic_rk;
    end

    // ---------------------------------------------------------------
    // Slot cell row. The free token ripples from cell to cell so that
    // only the first empty slot claims an insert.
    // ---------------------------------------------------------------
    assign w_free_chain[0] = 1'b0;

    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        lfu_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_probe    (w_probe),
            .i_cmd      (w_cmd),
            .i_free_in  (w_free_chain[c]),
            .o_free_out (w_free_chain[c+1]),
            .o_report   (w_rpt[c])
        );
    end

    // Gather the registered cell flags; at most one cell matches
    always_comb begin
        w_any_hit = 1'b0;
        w_hit_lv  = '0;
        w_hit_rk  = '0;
        for (int c = 0; c < CAPACITY; c++) begin
            w_any_hit       = w_any_hit | w_rpt[c].match;
            w_hit_lv        = w_hit_lv | w_rpt[c].level;
            w_hit_rk        = w_hit_rk | w_rpt[c].rank;
            w_valid_vec[c]  = w_rpt[c].valid;
            w_match_vec[c]  = w_rpt[c].match;
            w_free_vec[c]   = w_rpt[c].free;
            w_victim_vec[c] = w_rpt[c].victim;
        end
    end

    // ---------------------------------------------------------------
    // Decision: promote on a hit (nothing moves at the top level), insert
    // at the front of level 0 while room is left, else replace the victim
    // and put the new key at the back of level 0.
    // ---------------------------------------------------------------
    always_comb begin
        if (w_any_hit) begin
            w_op = (w_hit_lv == t_level'(LEVELS - 1)) ? OP_NONE : OP_PROMOTE;
        end else if (CMP_W'(r_occ) < w_cap_eff) begin
            w_op = OP_INSERT;
        end else begin
            w_op = OP_EVICT;
        end
    end

    always_comb begin
        w_cmd.commit   = w_commit;
        w_cmd.op       = w_op;
        w_cmd.lv       = w_hit_lv;
        w_cmd.lv_next  = w_hit_lv + t_level'(1);
        w_cmd.rk       = w_hit_rk;
        // a victim from level 0 keeps its place at the back; from a higher
        // level, level 0 is empty and the new key lands at rank 0
        w_cmd.new_rank = (w_vic_lv == '0) ? w_vic_rk : '0;
        w_cmd.key      = r_key;
    end

    // Level population, occupancy and hit tally follow the committed op
    always_comb begin
        n_occ   = r_occ;
        n_tally = r_tally;
        for (int l = 0; l < LEVELS; l++) begin
            n_lvl_cnt[l] = r_lvl_cnt[l];
        end
        if (w_commit) begin
            if (w_any_hit) begin
                n_tally = r_tally + TALLY_W'(1);
            end
            case (w_op)
                OP_PROMOTE: begin
                    for (int l = 0; l < LEVELS; l++) begin
                        if (t_level'(l) == w_cmd.lv) begin
                            n_lvl_cnt[l] = r_lvl_cnt[l] - t_count'(1);
                        end else if (t_level'(l) == w_cmd.lv_next) begin
                            n_lvl_cnt[l] = r_lvl_cnt[l] + t_count'(1);
                        end
                    end
                end
                OP_INSERT: begin
                    n_lvl_cnt[0] = r_lvl_cnt[0] + t_count'(1);
                    n_occ        = r_occ + t_count'(1);
                end
                OP_EVICT: begin
                    for (int l = 1; l < LEVELS; l++) begin
                        if (t_level'(l) == w_vic_lv) begin
                            n_lvl_cnt[l] = r_lvl_cnt[l] - t_count'(1);
                        end
                    end
                    if (w_vic_lv != '0) begin
                        n_lvl_cnt[0] = r_lvl_cnt[0] + t_count'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // State and output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (w_commit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_commit) begin
                r_out_valid <= 1'b1;
                r_hit       <= w_any_hit;
                r_total     <= n_tally;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_occ   <= '0;
            r_tally <= '0;
            for (int l = 0; l < LEVELS; l++) begin
                r_lvl_cnt[l] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_occ   <= n_occ;
            r_tally <= n_tally;
            for (int l = 0; l < LEVELS; l++) begin
                r_lvl_cnt[l] <= n_lvl_cnt[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= t_key'(i_access_key);
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match_vec))
        else $error("more than one slot holds the same key");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(w_valid_vec) == int'(r_occ)))
        else $error("occupancy out of step with slot valids");

    a_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (w_op == OP_EVICT)) |-> $onehot(w_victim_vec))
        else $error("eviction without exactly one victim");

    a_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (w_op == OP_INSERT)) |-> $onehot(w_free_vec))
        else $error("insert without exactly one free slot");

    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && (CMP_W'(r_occ) < CMP_W'(CAPACITY)))
        |-> w_free_chain[CAPACITY])
        else $error("no empty slot below full occupancy");

endmodule

`default_nettype wire

// ----- tb/sv/lfu_level_cache_policy_unit_test.sv -----
`default_nettype none

module lfu_level_cache_policy_unit_test;

    import lfu_pkg::*;

    // One expected result transaction
    typedef struct packed {
        logic               hit;
        logic [TALLY_W-1:0] total;
    } t_verdict;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Stimulus side, all driven at the falling edge
    logic                       in_valid  = 1'b0;
    logic signed [IN_KEY_W-1:0] in_key    = '0;
    logic                       out_stall = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [CFG_W-1:0]           cfg_data  = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_hit;
    logic [TALLY_W-1:0] o_hit_total;

    // Keys waiting to be offered, and results still owed by the block
    logic [IN_KEY_W-1:0] key_q[$];
    t_verdict            verdict_q[$];

    logic in_taken = 1'b0;   // input transaction accepted at the last rising edge
    int   errors   = 0;

    // Idling controls, set per phase by the stimulus process
    bit send_calm  = 1'b0;
    bit recv_calm  = 1'b0;
    bit press_on   = 1'b0;
    bit press_done = 1'b0;
    int press_left = 0;

    // Shadow of the slot row
    logic [KEY_WIDTH-1:0] sh_key   [CAPACITY];
    bit                   sh_valid [CAPACITY];
    int                   sh_level [CAPACITY];
    int                   sh_rank  [CAPACITY];
    int                   sh_occ   = 0;
    logic [TALLY_W-1:0]   sh_hits  = '0;
    logic [CFG_W-1:0]     sh_cap   = CAP_RESET;

    lfu_level_cache_policy_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_access_key (in_key),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_hit        (o_hit),
        .o_hit_total  (o_hit_total),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one access to the shadow row and returns what the block must answer.
    function automatic t_verdict apply_access(logic [KEY_WIDTH-1:0] key);
        int       room;
        int       found;
        int       lv;
        int       old_rank;
        int       free_slot;
        int       victim;
        int       n0;
        t_verdict v;
        room = sh_cap;
        if (room == 0) room = 1;               // zero acts as one
        if (room > CAPACITY) room = CAPACITY;  // saturate at the row size
        found = -1;
        for (int i = 0; i < CAPACITY; i++)
            if (found < 0 && sh_valid[i] && sh_key[i] == key) found = i;

        if (found >= 0) begin
            sh_hits++;
            lv = sh_level[found];
            if (lv + 1 < LEVELS) begin
                // leave the current level, go to the front of the next one
                old_rank = sh_rank[found];
                for (int i = 0; i < CAPACITY; i++) begin
                    if (i != found && sh_valid[i] && sh_level[i] == lv && sh_rank[i] > old_rank)
                        sh_rank[i]--;
                    if (i != found && sh_valid[i] && sh_level[i] == lv + 1)
                        sh_rank[i]++;
                end
                sh_level[found] = lv + 1;
                sh_rank[found]  = 0;
            end
            v.hit = 1'b1;
        end else if (sh_occ < room) begin
            free_slot = -1;
            for (int i = 0; i < CAPACITY; i++)
                if (free_slot < 0 && !sh_valid[i]) free_slot = i;
            if (free_slot >= 0) begin
                for (int i = 0; i < CAPACITY; i++)
                    if (sh_valid[i] && sh_level[i] == 0) sh_rank[i]++;
                sh_valid[free_slot] = 1'b1;
                sh_key[free_slot]   = key;
                sh_level[free_slot] = 0;
                sh_rank[free_slot]  = 0;
                sh_occ++;
            end
            v.hit = 1'b0;
        end else begin
            // evict the back entry of the lowest level that holds anything
            victim = -1;
            for (lv = 0; lv < LEVELS && victim < 0; lv++)
                for (int i = 0; i < CAPACITY; i++)
                    if (sh_valid[i] && sh_level[i] == lv &&
                        (victim < 0 || sh_rank[i] > sh_rank[victim]))
                        victim = i;
            if (victim >= 0) begin
                n0 = 0;
                for (int i = 0; i < CAPACITY; i++)
                    if (i != victim && sh_valid[i] && sh_level[i] == 0) n0++;
                sh_rank[victim]  = n0;   // newcomer joins level 0 at the back
                sh_key[victim]   = key;
                sh_level[victim] = 0;
            end
            v.hit = 1'b0;
        end
        v.total = sh_hits;
        return v;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Appends one key to the pending stimulus
    task automatic queue_key(logic [IN_KEY_W-1:0] k);
        key_q = {key_q, k};
    endtask

    // Driver: next key is loaded once the current transaction has gone
    always @(negedge i_clk) begin
        if (!in_valid || in_taken) begin
            if (key_q.size() > 0 && (send_calm || $urandom_range(99) >= 36)) begin
                in_valid <= 1'b1;
                in_key   <= key_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, or a long hold-off once to back the block up
    always @(negedge i_clk) begin
        if (press_on && !press_done) begin
            press_left <= 80;
            press_done <= 1'b1;
            out_stall  <= 1'b1;
        end else if (press_left > 0) begin
            press_left <= press_left - 1;
            out_stall  <= 1'b1;
        end else if (recv_calm) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < 36);
        end
    end

    // Monitor: predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin : monitor
        t_verdict want;
        in_taken <= in_valid && !o_in_stall;
        if (i_rst_n && in_valid && !o_in_stall)
            verdict_q = {verdict_q, apply_access(in_key)};
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result transaction with nothing outstanding");
            end else begin
                want = verdict_q.pop_front();
                if (o_hit !== want.hit)
                    report_mismatch($sformatf("hit %b, expected %b", o_hit, want.hit));
                if (o_hit_total !== want.total)
                    report_mismatch($sformatf("hit_total %0d, expected %0d",
                                              o_hit_total, want.total));
            end
        end
    end

    // Wait until the block has nothing in hand
    task automatic drain();
        while (key_q.size() > 0 || in_valid || verdict_q.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [CFG_W-1:0] v);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        sh_cap = v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly keys from a small pool with a hot few, so keys climb the levels;
    // the rest are fresh random keys and the extreme values.
    task automatic run_phase(int cap_val, int n, int pool_n, bit calm_all, bit squeeze);
        logic [IN_KEY_W-1:0] pool[$];
        logic [IN_KEY_W-1:0] corner[4];
        int                  r;
        corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        drain();
        set_capacity(CFG_W'(cap_val));
        for (int i = 0; i < pool_n; i++) pool = {pool, $urandom};
        send_calm = calm_all || squeeze;
        recv_calm = calm_all;
        press_on  = squeeze;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 30)      queue_key(pool[$urandom_range((pool_n < 3 ? pool_n : 3) - 1)]);
            else if (r < 75) queue_key(pool[$urandom_range(pool_n - 1)]);
            else if (r < 90) queue_key($urandom);
            else             queue_key(corner[$urandom_range(3)]);
        end
        drain();
        send_calm = 1'b0;
        recv_calm = 1'b0;
        press_on  = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < CAPACITY; i++) sh_valid[i] = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, alternating bits, one key climbing to the top level and hit there again
        queue_key(32'h0000_0000);
        queue_key(32'hFFFF_FFFF);
        queue_key(32'h8000_0000);
        queue_key(32'h7FFF_FFFF);
        queue_key(32'h5555_5555);
        queue_key(32'hAAAA_AAAA);
        for (int i = 0; i < 11; i++) queue_key(32'h0000_0000);
        queue_key(32'h8000_0000);
        queue_key(32'hFFFF_FFFF);
        queue_key(32'hAAAA_AAAA);
        drain();

        // Capacity zero while six keys are held: each miss evicts one
        set_capacity(CFG_W'(0));
        queue_key(32'h1234_5678);
        queue_key(32'h1234_5678);
        queue_key(32'hDEAD_BEEF);
        queue_key(32'h0000_0000);
        queue_key(32'h7FFF_FFFF);
        drain();

        run_phase(1,   50,  3,  1'b0, 1'b0);
        run_phase(2,   60,  5,  1'b0, 1'b0);
        run_phase(64,  90,  80, 1'b0, 1'b0);
        run_phase(5,   60,  8,  1'b0, 1'b1);   // lowered below occupancy, long hold-off
        run_phase(127, 80,  70, 1'b1, 1'b0);   // saturates; no idling on either side
        run_phase(0,   40,  3,  1'b0, 1'b0);
        run_phase($urandom_range(1, 127), 70, $urandom_range(4, 90), 1'b0, 1'b0);
        run_phase(16,  80,  24, 1'b0, 1'b0);
        run_phase(40,  90,  50, 1'b0, 1'b0);

        drain();
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
